/* rtl/core/dlr_pkg.sv */
// ----------------------------------------------------------------------------
// dlr_pkg
// Shared widths, codes and controller types of the DDA line rasteriser.
// ----------------------------------------------------------------------------
package dlr_pkg;

  localparam int unsigned COORD_BITS    = 13;
  localparam int unsigned FRAC_BITS     = 16;
  localparam int unsigned POS_BITS      = COORD_BITS + FRAC_BITS;
  localparam int unsigned STEP_BITS     = FRAC_BITS + 2;
  localparam int unsigned DELTA_BITS    = COORD_BITS + 1;
  localparam int unsigned LEN2_BITS     = 2 * DELTA_BITS;
  localparam int unsigned CNT_BITS      = DELTA_BITS;
  localparam int unsigned SQ_REM_BITS   = CNT_BITS + 1;
  localparam int unsigned ITER_BITS     = $clog2(POS_BITS + 1);

  localparam int unsigned ADDR_BITS     = 32;
  localparam int unsigned COLOR_BITS    = 32;
  localparam int unsigned BASE_BITS     = 32;
  localparam int unsigned STRIDE_BITS   = 16;
  localparam int unsigned BPP_BITS      = 3;
  localparam int unsigned DIM_BITS      = 12;
  localparam int unsigned CFG_IDX_BITS  = 3;
  localparam int unsigned CFG_DATA_BITS = 32;
  localparam int unsigned CMP_BITS      =
    ((POS_BITS > DIM_BITS + FRAC_BITS) ? POS_BITS : DIM_BITS + FRAC_BITS) + 1;

  localparam logic [BPP_BITS-1:0] BPP_RESET = BPP_BITS'(4);

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_FRAME_BASE      = 3'd0,
    CFG_ROW_STRIDE      = 3'd1,
    CFG_BYTES_PER_PIXEL = 3'd2,
    CFG_FRAME_WIDTH     = 3'd3,
    CFG_FRAME_HEIGHT    = 3'd4
  } cfg_reg_e;

  typedef enum logic {
    CMD_START = 1'b0,
    CMD_STEP  = 1'b1
  } cmd_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SQUARE,
    ST_SUM,
    ST_SQRT,
    ST_DIV_LOAD,
    ST_DIV,
    ST_FINISH,
    ST_PIX_MUL,
    ST_PIX_OUT
  } state_e;

  typedef struct packed {
    logic line_load;
    logic square;
    logic sum;
    logic sqrt_step;
    logic div_load;
    logic div_step;
    logic finish;
    logic pix_load;
    logic pix_mul;
    logic out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic pixels_zero;
    logic count_zero;
    logic out_free;
  } dp_sts_t;

endpackage

/* rtl/core/dlr_ctrl.sv */
// ----------------------------------------------------------------------------
// dlr_ctrl
// Sequencer of the rasteriser: line set-up through square root and division,
// and the pixel address path through to the output register.
// ----------------------------------------------------------------------------
module dlr_ctrl
  import dlr_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  input  logic    cmd_i,
  output logic    in_stall_o,
  input  dp_sts_t sts_i,
  output dp_cmd_t cmd_o
);

  state_e               state_q, state_d;
  logic [ITER_BITS-1:0] iter_q, iter_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      iter_q  <= '0;
    end else begin
      state_q <= state_d;
      iter_q  <= iter_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    iter_d     = iter_q;
    cmd_o      = '0;
    in_stall_o = 1'b1;
    unique case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          if (cmd_i == CMD_START) begin
            cmd_o.line_load = 1'b1;
            state_d         = ST_SQUARE;
          end else if (!sts_i.pixels_zero) begin
            cmd_o.pix_load = 1'b1;
            state_d        = ST_PIX_MUL;
          end
        end
      end
      ST_SQUARE: begin
        cmd_o.square = 1'b1;
        state_d      = ST_SUM;
      end
      ST_SUM: begin
        cmd_o.sum = 1'b1;
        iter_d    = '0;
        state_d   = ST_SQRT;
      end
      ST_SQRT: begin
        cmd_o.sqrt_step = 1'b1;
        iter_d          = iter_q + ITER_BITS'(1);
        if (iter_q == ITER_BITS'(CNT_BITS - 1)) begin
          state_d = ST_DIV_LOAD;
        end
      end
      ST_DIV_LOAD: begin
        if (sts_i.count_zero) begin
          cmd_o.finish = 1'b1;
          state_d      = ST_IDLE;
        end else begin
          cmd_o.div_load = 1'b1;
          iter_d         = '0;
          state_d        = ST_DIV;
        end
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        iter_d         = iter_q + ITER_BITS'(1);
        if (iter_q == ITER_BITS'(POS_BITS - 1)) begin
          state_d = ST_FINISH;
        end
      end
      ST_FINISH: begin
        cmd_o.finish = 1'b1;
        state_d      = ST_IDLE;
      end
      ST_PIX_MUL: begin
        cmd_o.pix_mul = 1'b1;
        state_d       = ST_PIX_OUT;
      end
      ST_PIX_OUT: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

/* rtl/core/dlr_dp.sv */
// ----------------------------------------------------------------------------
// dlr_dp
// Datapath of the rasteriser: configuration registers, line length square
// root, per-axis step division, position accumulators and pixel address.
// ----------------------------------------------------------------------------
module dlr_dp
  import dlr_pkg::*;
(
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [CFG_IDX_BITS-1:0]      cfg_index_i,
  input  logic [CFG_DATA_BITS-1:0]     cfg_data_i,
  input  logic signed [COORD_BITS-1:0] start_x_i,
  input  logic signed [COORD_BITS-1:0] start_y_i,
  input  logic signed [COORD_BITS-1:0] end_x_i,
  input  logic signed [COORD_BITS-1:0] end_y_i,
  input  logic [COLOR_BITS-1:0]        line_color_i,
  input  dp_cmd_t                      cmd_i,
  output dp_sts_t                      sts_o,
  input  logic                         out_stall_i,
  output logic                         out_valid_o,
  output logic [ADDR_BITS-1:0]         pixel_address_o,
  output logic [COLOR_BITS-1:0]        pixel_value_o,
  output logic                         write_enable_o,
  output logic                         last_pixel_o
);

  // configuration
  logic [BASE_BITS-1:0]   frame_base_q;
  logic [STRIDE_BITS-1:0] row_stride_q;
  logic [BPP_BITS-1:0]    bpp_q;
  logic [DIM_BITS-1:0]    frame_width_q;
  logic [DIM_BITS-1:0]    frame_height_q;

  // line state
  logic signed [POS_BITS-1:0]   pos_q   [2];
  logic signed [POS_BITS-1:0]   pos_d   [2];
  logic signed [STEP_BITS-1:0]  step_q  [2];
  logic signed [STEP_BITS-1:0]  step_d  [2];
  logic [CNT_BITS-1:0]          pixels_left_q;
  logic [COLOR_BITS-1:0]        color_q;

  // set-up
  logic signed [DELTA_BITS-1:0] dlt_q   [2];
  logic [LEN2_BITS-1:0]         sq_q    [2];
  logic [LEN2_BITS-1:0]         rad_q, rad_d;
  logic [SQ_REM_BITS-1:0]       sq_rem_q, sq_rem_d;
  logic [CNT_BITS-1:0]          root_q, root_d;
  logic [SQ_REM_BITS+1:0]       sq_sh;
  logic [SQ_REM_BITS+1:0]       sq_trial;
  logic [CNT_BITS-1:0]          drem_q  [2];
  logic [CNT_BITS-1:0]          drem_d  [2];
  logic [POS_BITS-1:0]          dnum_q  [2];
  logic [POS_BITS-1:0]          dnum_d  [2];
  logic [CNT_BITS:0]            div_sh  [2];
  logic [COORD_BITS-1:0]        mag     [2];
  logic [STEP_BITS-1:0]         quo     [2];

  // pixel path
  logic signed [CMP_BITS-1:0]   pos_ext [2];
  logic signed [CMP_BITS-1:0]   lim     [2];
  logic signed [COORD_BITS-1:0] trunc_c [2];
  logic signed [COORD_BITS-1:0] tc_q    [2];
  logic                         inside_d;
  logic                         inside_q;
  logic                         last_q;
  logic [COLOR_BITS-1:0]        pcolor_q;
  logic [ADDR_BITS-1:0]         prod_y_q, prod_x_q;
  logic [ADDR_BITS-1:0]         ext_y, ext_x;
  logic                         out_valid_q;

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_base_q   <= '0;
      row_stride_q   <= '0;
      bpp_q          <= BPP_RESET;
      frame_width_q  <= '0;
      frame_height_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        CFG_FRAME_BASE:      frame_base_q   <= cfg_data_i[BASE_BITS-1:0];
        CFG_ROW_STRIDE:      row_stride_q   <= cfg_data_i[STRIDE_BITS-1:0];
        CFG_BYTES_PER_PIXEL: bpp_q          <= cfg_data_i[BPP_BITS-1:0];
        CFG_FRAME_WIDTH:     frame_width_q  <= cfg_data_i[DIM_BITS-1:0];
        CFG_FRAME_HEIGHT:    frame_height_q <= cfg_data_i[DIM_BITS-1:0];
        default: ;
      endcase
    end
  end

  // square root, one result bit per cycle
  always_comb begin
    sq_sh    = {sq_rem_q, rad_q[LEN2_BITS-1 -: 2]};
    sq_trial = (SQ_REM_BITS+2)'({root_q, 2'b01});
    rad_d    = rad_q << 2;
    if (sq_sh >= sq_trial) begin
      sq_rem_d = SQ_REM_BITS'(sq_sh - sq_trial);
      root_d   = {root_q[CNT_BITS-2:0], 1'b1};
    end else begin
      sq_rem_d = sq_sh[SQ_REM_BITS-1:0];
      root_d   = {root_q[CNT_BITS-2:0], 1'b0};
    end
  end

  // restoring division lanes, step sign and position advance
  always_comb begin
    for (int l = 0; l < 2; l++) begin
      mag[l]    = dlt_q[l][DELTA_BITS-1] ? COORD_BITS'(-dlt_q[l])
                                          : COORD_BITS'(dlt_q[l]);
      div_sh[l] = {drem_q[l], dnum_q[l][POS_BITS-1]};
      if (div_sh[l] >= {1'b0, root_q}) begin
        drem_d[l] = CNT_BITS'(div_sh[l] - {1'b0, root_q});
        dnum_d[l] = {dnum_q[l][POS_BITS-2:0], 1'b1};
      end else begin
        drem_d[l] = div_sh[l][CNT_BITS-1:0];
        dnum_d[l] = {dnum_q[l][POS_BITS-2:0], 1'b0};
      end
      quo[l] = dnum_q[l][STEP_BITS-1:0];
      if (root_q == '0) begin
        step_d[l] = '0;
      end else if (dlt_q[l][DELTA_BITS-1]) begin
        step_d[l] = signed'(-quo[l]);
      end else begin
        step_d[l] = signed'(quo[l]);
      end
      pos_d[l] = pos_q[l] + POS_BITS'(step_q[l]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q[0]      <= '0;
      pos_q[1]      <= '0;
      step_q[0]     <= '0;
      step_q[1]     <= '0;
      pixels_left_q <= '0;
      color_q       <= '0;
    end else begin
      if (cmd_i.line_load) begin
        pos_q[0]      <= {start_x_i, {FRAC_BITS{1'b0}}};
        pos_q[1]      <= {start_y_i, {FRAC_BITS{1'b0}}};
        step_q[0]     <= '0;
        step_q[1]     <= '0;
        pixels_left_q <= '0;
        color_q       <= line_color_i;
      end else if (cmd_i.finish) begin
        step_q[0]     <= step_d[0];
        step_q[1]     <= step_d[1];
        pixels_left_q <= root_q;
      end else if (cmd_i.pix_load) begin
        pos_q[0]      <= pos_d[0];
        pos_q[1]      <= pos_d[1];
        pixels_left_q <= pixels_left_q - CNT_BITS'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.line_load) begin
      dlt_q[0] <= DELTA_BITS'(end_x_i) - DELTA_BITS'(start_x_i);
      dlt_q[1] <= DELTA_BITS'(end_y_i) - DELTA_BITS'(start_y_i);
    end
    if (cmd_i.square) begin
      sq_q[0] <= LEN2_BITS'(dlt_q[0] * dlt_q[0]);
      sq_q[1] <= LEN2_BITS'(dlt_q[1] * dlt_q[1]);
    end
    if (cmd_i.sum) begin
      rad_q    <= sq_q[0] + sq_q[1];
      sq_rem_q <= '0;
      root_q   <= '0;
    end else if (cmd_i.sqrt_step) begin
      rad_q    <= rad_d;
      sq_rem_q <= sq_rem_d;
      root_q   <= root_d;
    end
    for (int l = 0; l < 2; l++) begin
      if (cmd_i.div_load) begin
        drem_q[l] <= '0;
        dnum_q[l] <= {mag[l], {FRAC_BITS{1'b0}}};
      end else if (cmd_i.div_step) begin
        drem_q[l] <= drem_d[l];
        dnum_q[l] <= dnum_d[l];
      end
    end
  end

  // pixel: truncate toward zero, bounds test on the full position
  always_comb begin
    lim[0] = signed'(CMP_BITS'({frame_width_q, {FRAC_BITS{1'b0}}}));
    lim[1] = signed'(CMP_BITS'({frame_height_q, {FRAC_BITS{1'b0}}}));
    for (int l = 0; l < 2; l++) begin
      pos_ext[l] = CMP_BITS'(pos_q[l]);
      trunc_c[l] = COORD_BITS'(pos_q[l] >>> FRAC_BITS)
                 + COORD_BITS'(pos_q[l][POS_BITS-1] && (pos_q[l][FRAC_BITS-1:0] != '0));
    end
    inside_d = (pos_ext[0] > 0) && (pos_ext[0] < lim[0])
            && (pos_ext[1] > 0) && (pos_ext[1] < lim[1]);
    ext_y    = ADDR_BITS'(tc_q[1]);
    ext_x    = ADDR_BITS'(tc_q[0]);
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.pix_load) begin
      tc_q[0]  <= trunc_c[0];
      tc_q[1]  <= trunc_c[1];
      inside_q <= inside_d;
      last_q   <= (pixels_left_q == CNT_BITS'(1));
      pcolor_q <= color_q;
    end
    if (cmd_i.pix_mul) begin
      prod_y_q <= ext_y * ADDR_BITS'(row_stride_q);
      prod_x_q <= ext_x * ADDR_BITS'(bpp_q);
    end
    if (cmd_i.out_load) begin
      pixel_address_o <= frame_base_q + prod_y_q + prod_x_q;
      pixel_value_o   <= pcolor_q;
      write_enable_o  <= inside_q;
      last_pixel_o    <= last_q;
    end
  end

  // output register: hold while stalled
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign sts_o.out_free    = !out_valid_q || !out_stall_i;
  assign sts_o.pixels_zero = (pixels_left_q == '0);
  assign sts_o.count_zero  = (root_q == '0);

endmodule

/* rtl/core/dda_line_rasterizer.sv */
// ----------------------------------------------------------------------------
// dda_line_rasterizer
// DDA line drawer producing one frame buffer pixel write per step.
// ----------------------------------------------------------------------------
// Input channel (in_valid_i / in_stall_o): cmd_i = 0 starts a line from the
// two endpoints and line_color_i; cmd_i = 1 steps to the next pixel.
// Output channel (out_valid_o / out_stall_i): one pixel write per step while
// pixels remain; last_pixel_o marks the final one, write_enable_o is set only
// strictly inside the frame.
// A start transaction gives no result and keeps the input stalled through
// the squares and their sum, the bit-serial square root (one root bit per
// cycle), the divider load, the two restoring divider lanes (one quotient
// bit per cycle) and the step load. A line of length zero finishes after
// the square root and skips the division.
// A step transaction is captured and advanced, then goes through the
// address multiplies, then the adder into the output register; the input
// stays stalled until that load. A step with no pixels left is taken and
// dropped. The output register holds a result while out_stall_i is high;
// the next transaction may be accepted meanwhile, the address path waits.
// Reset clears the line state and the configuration (4 bytes per pixel).
// ----------------------------------------------------------------------------
module dda_line_rasterizer
  import dlr_pkg::*;
(
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [CFG_IDX_BITS-1:0]      cfg_index_i,
  input  logic [CFG_DATA_BITS-1:0]     cfg_data_i,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic                         cmd_i,
  input  logic signed [COORD_BITS-1:0] start_x_i,
  input  logic signed [COORD_BITS-1:0] start_y_i,
  input  logic signed [COORD_BITS-1:0] end_x_i,
  input  logic signed [COORD_BITS-1:0] end_y_i,
  input  logic [COLOR_BITS-1:0]        line_color_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [ADDR_BITS-1:0]         pixel_address_o,
  output logic [COLOR_BITS-1:0]        pixel_value_o,
  output logic                         write_enable_o,
  output logic                         last_pixel_o
);

  dp_cmd_t dp_cmd;
  dp_sts_t dp_sts;

  dlr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .cmd_i      (cmd_i),
    .in_stall_o (in_stall_o),
    .sts_i      (dp_sts),
    .cmd_o      (dp_cmd)
  );

  dlr_dp u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .start_x_i       (start_x_i),
    .start_y_i       (start_y_i),
    .end_x_i         (end_x_i),
    .end_y_i         (end_y_i),
    .line_color_i    (line_color_i),
    .cmd_i           (dp_cmd),
    .sts_o           (dp_sts),
    .out_stall_i     (out_stall_i),
    .out_valid_o     (out_valid_o),
    .pixel_address_o (pixel_address_o),
    .pixel_value_o   (pixel_value_o),
    .write_enable_o  (write_enable_o),
    .last_pixel_o    (last_pixel_o)
  );

endmodule
